FILE: rtl/clo_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the color layer over compositor.
// Used by clo_div and color_layer_over_compositor; depends on nothing.
package clo_pkg;

  // Canvas geometry and pixel store.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = XW + YW;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int LANES      = 3;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = 11;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     CANVAS_RESET      = 7'd64;

  // Item kinds carried on the input tuser.
  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Stream payload widths.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Blend arithmetic: numerators reach 255 * 65025, the weight sum 65025.
  localparam int NUM_W = 25;
  localparam int DEN_W = 16;
  localparam int MP_W  = CHAN_W + DEN_W;
  localparam int Q_W   = 8;

  typedef logic [LANES-1:0][NUM_W-1:0]  lane_num_t;
  typedef logic [LANES-1:0][Q_W-1:0]    lane_quo_t;
  typedef logic [LANES-1:0][CHAN_W-1:0] lane_chan_t;
  typedef logic [LANES-1:0][DEN_W-1:0]  lane_prod_t;

endpackage

FILE: rtl/clo_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on clo_pkg for widths and lane types.
module clo_div
  import clo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lane_num_t  num,
  input  logic [DEN_W-1:0] den,
  output logic       done,
  output lane_quo_t  quo
);

  localparam int SH_W  = DEN_W + Q_W - 1;
  localparam int CNT_W = $clog2(Q_W);

  lane_num_t          rem;
  logic [SH_W-1:0]    dsh;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  // The quotient is known to fit in Q_W bits, so the divisor starts shifted
  // up by Q_W-1 and walks down one place per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W - 1);
        dsh  <= {den, {(Q_W-1){1'b0}}};
        rem  <= num;
      end else if (busy) begin
        for (int i = 0; i < LANES; i++) begin
          if (rem[i] >= NUM_W'(dsh)) begin
            rem[i] <= rem[i] - NUM_W'(dsh);
            quo[i] <= {quo[i][Q_W-2:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][Q_W-2:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/color_layer_over_compositor.sv
`timescale 1ns / 1ps
// Top level of the color layer over compositor: BGRA canvas store and blend control.
// Depends on clo_pkg and instantiates clo_div.
//
// The block keeps a 64 x 64 canvas of BGRA pixels in one synchronous memory.
// Each beat on the s_ channel is one item: tuser selects a blend (0) or a
// read-and-clear (1), tdata carries the destination coordinate, the coverage
// byte and the layer color. Each item yields exactly one beat on the m_
// channel, whose tuser flags whether the coordinate lay inside the canvas and
// whose tdata is the pixel after the blend, or as it was before the clear.
// Items are handled one at a time. An out-of-bounds item goes straight to
// the result, a read waits only for the memory read, and a blend passes
// through the memory read, two multiply stages and the eight-step
// divider that forms each color channel. The result beat is offered in the
// same cycle in which the next item may be accepted.
// After reset the block walks the store writing zero to one pixel per cycle
// over all 4096 entries, and holds s_tready low meanwhile; configuration writes are
// taken at any time. A finished result waits in the output register while the
// receiver stalls, and the next item is accepted in the meantime; the block
// only waits if a second result is ready before the first one has been taken.
module color_layer_over_compositor
  import clo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // Input items.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dest_x[8:0], dest_y[17:9], coverage[25:18], color_red[33:26],
  // color_green[41:34], color_blue[49:42], zero fill [55:50]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // mode
  // Result items.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16], pixel_alpha[31:24]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser    // in_bounds
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WAIT, ST_MUL, ST_SUM, ST_DIV, ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0] canvas_width;
  logic [CFG_W-1:0] canvas_height;

  // Pixel store.
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] clr_cnt;

  // Item registers.
  logic              mode_q;
  logic              inb_q;
  logic [ADDR_W-1:0] addr;
  logic [CHAN_W-1:0] cov_q;
  lane_chan_t        col_q;
  logic [PIX_W-1:0]  pix;
  logic              wr_q;
  lane_prod_t        prod_q;
  logic [DEN_W-1:0]  p_q;
  logic [DEN_W-1:0]  den_q;
  lane_num_t         num_q;
  logic [CHAN_W-1:0] alpha_q;
  logic              div_start;

  // Divider results.
  logic      div_done;
  lane_quo_t quo;

  // Input unpacking and bounds check.
  logic [8:0]        x_raw;
  logic [8:0]        y_raw;
  logic [CMP_W-1:0]  w_lim;
  logic [CMP_W-1:0]  h_lim;
  logic              inb;
  logic [ADDR_W-1:0] addr_next;
  lane_chan_t        col_in;

  // Blend arithmetic.
  lane_prod_t        prod_next;
  logic [DEN_W-1:0]  p_next;
  logic [MP_W-1:0]   mp [LANES];
  lane_num_t         num_next;
  logic [DEN_W:0]    n_sum;
  logic [DEN_W-1:0]  den_next;
  logic [DEN_W-1:0]  a_sum;

  logic out_free;
  logic accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // A register beyond the configured maximum acts as the maximum; zero puts
  // every coordinate outside. A negative coordinate has its sign bit set.
  always_comb begin
    x_raw     = s_tdata[8:0];
    y_raw     = s_tdata[17:9];
    col_in[0] = s_tdata[49:42];
    col_in[1] = s_tdata[41:34];
    col_in[2] = s_tdata[33:26];
    w_lim = (CMP_W'(canvas_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                       : CMP_W'(canvas_width);
    h_lim = (CMP_W'(canvas_height) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                         : CMP_W'(canvas_height);
    inb = !x_raw[8] && !y_raw[8] &&
          (CMP_W'(x_raw[7:0]) < w_lim) && (CMP_W'(y_raw[7:0]) < h_lim);
    addr_next = {YW'(y_raw[7:0]), XW'(x_raw[7:0])};
  end

  // First multiply stage: color times coverage per lane, and the weight of
  // the old pixel, da * (255 - sa).
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_next[i] = DEN_W'(col_q[i]) * DEN_W'(cov_q);
    end
    p_next = DEN_W'(rdata[31:24]) * DEN_W'(8'd255 - cov_q);
  end

  // Second stage: numerators, the weight sum N and the new alpha N / 255.
  // (N + 1 + (N >> 8)) >> 8 is exact for every N up to 65025, the largest weight sum.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mp[i]       = MP_W'(pix[i*CHAN_W +: CHAN_W]) * MP_W'(p_q);
      num_next[i] = NUM_W'({prod_q[i], 8'd0}) - NUM_W'(prod_q[i]) + NUM_W'(mp[i]);
    end
    n_sum    = (DEN_W+1)'({cov_q, 8'd0}) - (DEN_W+1)'(cov_q) + (DEN_W+1)'(p_q);
    den_next = n_sum[DEN_W-1:0];
    a_sum    = den_next + DEN_W'(1) + DEN_W'(den_next[15:8]);
  end

  // Store write port: the clearing sweep, or the write-back of a finished
  // item in the cycle its result enters the output register.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == ST_DONE) && out_free && wr_q;
      mem_waddr = addr;
      mem_wdata = (mode_q == MODE_READ) ? '0 : pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_RESET;
      canvas_height <= CANVAS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  clo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_q),
    .den   (den_q),
    .done  (div_done),
    .quo   (quo)
  );

  // Item sequencer. Only one item is in flight, so a write-back always lands
  // before the next item reads the store and no forwarding is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // The divider starts on the cycle after the sum stage found a weight.
      div_start <= (state == ST_SUM) && (den_next != '0);
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_q <= s_tuser;
            inb_q  <= inb;
            addr   <= addr_next;
            cov_q  <= s_tdata[25:18];
            col_q  <= col_in;
            pix    <= '0;
            wr_q   <= 1'b0;
            state  <= inb ? ST_WAIT : ST_DONE;
          end
        end
        ST_WAIT: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          pix    <= rdata;
          prod_q <= prod_next;
          p_q    <= p_next;
          if (mode_q == MODE_READ) begin
            wr_q  <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (den_next == '0) begin
            // Nothing to blend: the stored pixel stays and is returned.
            state <= ST_DONE;
          end else begin
            num_q     <= num_next;
            den_q     <= den_next;
            alpha_q   <= a_sum[15:8];
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            pix   <= {alpha_q, quo[2], quo[1], quo[0]};
            wr_q  <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tuser  <= inb_q;
            m_tdata  <= pix;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An out-of-bounds result carries an all-zero pixel.
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("out-of-bounds result carries a nonzero pixel");

  // One item at a time: an accepted beat closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again while an item is in flight");

  // The store is never written while the block waits for an item.
  a_idle_nowrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // The over rule never lowers alpha below the coverage of the layer.
  a_alpha_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && wr_q && mode_q == MODE_BLEND) |-> (pix[31:24] >= cov_q))
    else $error("blended alpha below coverage");

endmodule
